/* design/assert_macros.svh */
// Assertion macros used by the controller top level.
// No dependencies; the including module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define MWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define MWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/mwc_pkg.sv */
// Package for the moisture watering controller: register indexes, fixed
// constants and the sequencer state type. No dependencies.
`default_nettype none

package mwc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_HUMIDITY = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WET_READING     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DRY_READING     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WATER_UNITS     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MIN_GAP_MS      = 3'd4;

  localparam logic [31:0] START_GAP_MS = 32'd20000;
  localparam logic [6:0]  MS_PER_UNIT  = 7'd100;
  localparam logic [6:0]  FULL_SCALE   = 7'd100;

  localparam logic [6:0]  TARGET_RESET  = 7'd50;
  localparam logic [9:0]  WET_RESET     = 10'd1023;
  localparam logic [9:0]  DRY_RESET     = 10'd0;
  localparam logic [7:0]  UNITS_RESET   = 8'd10;
  localparam logic [31:0] MIN_GAP_RESET = 32'd20000;

  // Quotient magnitude width: |(sample - wet) * 100| < 2**17
  localparam int unsigned QuotW = 17;
  localparam logic [4:0] DIV_LAST = 5'(QuotW - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

/* design/moisture_watering_controller.sv */
// Moisture watering controller top level: millisecond bookkeeping, sample
// to humidity mapping through a serial divider, pump run control.
// Depends on mwc_pkg and assert_macros.svh.
`default_nettype none

// A tick item (mode 0) is finished on the edge that accepts it: its result
// is loaded into the output register on that same edge. A request item
// (mode 1) holds off further items until it is finished: S_MUL forms
// (sample - wet) * 100 on the shared 10x7 multiplier, S_DIV runs the
// one-bit-per-cycle restoring divider, and S_FIN finishes the mapping, the
// watering decision and the pump run length (the same multiplier forms
// water_units * 100), waiting while the output register is not free. The
// output register holds one finished result; a new item is taken only when
// that register is free or being emptied on the same edge. Configuration
// writes are registered and are meant for idle periods only.
module moisture_watering_controller (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [mwc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [mwc_pkg::CfgDataW-1:0]   cfg_data,
  // input requests
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode,
  input  wire logic [9:0]                     sample,
  // results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                pump_on,
  output logic signed [17:0]                  humidity,
  output logic signed [18:0]                  deficit,
  output logic                                watered,
  output logic                                pump_started,
  output logic                                span_error
);

  import mwc_pkg::*;

  // configuration registers
  logic [6:0]  target_humidity;
  logic [9:0]  wet_reading;
  logic [9:0]  dry_reading;
  logic [7:0]  water_units;
  logic [31:0] min_gap_ms;

  // block state
  logic [31:0] since_ms;
  logic [14:0] pump_left;

  // sequencer and datapath
  state_t          state;
  logic [4:0]      cnt;
  logic [9:0]      diff_mag;
  logic            num_neg;
  logic [9:0]      dsr;
  logic            span_neg;
  logic [QuotW-1:0] dvd;
  logic [9:0]      rem;

  logic out_free;
  logic in_acc;
  logic out_acc;
  logic out_load;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  // a result enters the output register on this edge
  assign out_load = ((state == S_IDLE) && in_acc && !mode) ||
                    ((state == S_FIN) && out_free);

  // request front end: magnitudes and signs of numerator and span
  logic signed [10:0] diff;
  logic signed [10:0] span;
  always_comb begin
    diff = signed'({1'b0, sample}) - signed'({1'b0, wet_reading});
    span = signed'({1'b0, dry_reading}) - signed'({1'b0, wet_reading});
  end

  // shared multiplier by 100: numerator in S_MUL, run length in S_FIN
  logic [9:0]  mul_a;
  logic [16:0] mul_p;
  always_comb begin
    mul_a = (state == S_FIN) ? {2'b00, water_units} : diff_mag;
    mul_p = 17'(mul_a * MS_PER_UNIT);
  end

  // one restoring divide step
  logic [10:0] trial;
  logic        ge;
  logic [9:0]  rem_next;
  always_comb begin
    trial    = {rem, dvd[QuotW-1]};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? 10'(trial - {1'b0, dsr}) : trial[9:0];
  end

  // tick bookkeeping
  logic [31:0] since_inc;
  logic [14:0] pump_dec;
  logic [31:0] tick_since_next;
  logic [14:0] tick_pump_next;
  always_comb begin
    since_inc = (since_ms != '1) ? since_ms + 32'd1 : since_ms;
    pump_dec  = pump_left - 15'd1;
    tick_pump_next  = pump_left;
    tick_since_next = since_inc;
    if (pump_left != '0) begin
      tick_pump_next = pump_dec;
      if (pump_dec == '0) tick_since_next = '0;
    end
  end

  // finish step: humidity, deficit and watering decision
  logic               q_neg;
  logic signed [17:0] quot;
  logic signed [17:0] hum;
  logic signed [18:0] def;
  logic               span_zero;
  logic               fin_watered;
  logic               fin_start;
  logic [14:0]        run_len;
  logic [31:0]        fin_since_next;
  logic [14:0]        fin_pump_next;
  always_comb begin
    q_neg     = num_neg ^ span_neg;
    quot      = q_neg ? -signed'({1'b0, dvd}) : signed'({1'b0, dvd});
    hum       = quot + signed'(18'(FULL_SCALE));
    def       = signed'({12'd0, target_humidity}) - 19'(hum);
    span_zero = (dsr == '0);
    run_len   = mul_p[14:0];
    fin_watered = !span_zero && (def > 19'sd0) && (since_ms > min_gap_ms);
    fin_start   = fin_watered && (since_ms > START_GAP_MS) && (pump_left == '0);
    fin_pump_next  = fin_start ? run_len : pump_left;
    fin_since_next = (fin_start && (run_len == '0)) ? '0 : since_ms;
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      target_humidity <= TARGET_RESET;
      wet_reading     <= WET_RESET;
      dry_reading     <= DRY_RESET;
      water_units     <= UNITS_RESET;
      min_gap_ms      <= MIN_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_HUMIDITY: target_humidity <= cfg_data[6:0];
        CFG_WET_READING:     wet_reading     <= cfg_data[9:0];
        CFG_DRY_READING:     dry_reading     <= cfg_data[9:0];
        CFG_WATER_UNITS:     water_units     <= cfg_data[7:0];
        CFG_MIN_GAP_MS:      min_gap_ms      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      since_ms  <= '0;
      pump_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_acc && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (mode) begin
              diff_mag <= diff[10] ? 10'(-diff) : diff[9:0];
              num_neg  <= !diff[10] && (diff != '0);
              dsr      <= span[10] ? 10'(-span) : span[9:0];
              span_neg <= span[10];
              state    <= S_MUL;
            end else begin
              since_ms     <= tick_since_next;
              pump_left    <= tick_pump_next;
              out_valid    <= 1'b1;
              pump_on      <= (tick_pump_next != '0);
              humidity     <= '0;
              deficit      <= '0;
              watered      <= 1'b0;
              pump_started <= 1'b0;
              span_error   <= 1'b0;
            end
          end
        end
        S_MUL: begin
          dvd   <= mul_p;
          rem   <= '0;
          cnt   <= DIV_LAST;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[QuotW-2:0], ge};
          cnt <= cnt - 5'd1;
          if (cnt == '0) state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            since_ms     <= fin_since_next;
            pump_left    <= fin_pump_next;
            out_valid    <= 1'b1;
            pump_on      <= (fin_pump_next != '0);
            humidity     <= span_zero ? '0 : hum;
            deficit      <= span_zero ? '0 : def;
            watered      <= fin_watered;
            pump_started <= fin_start;
            span_error   <= span_zero;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `MWC_ASSERT(a_span_err_clean, (out_valid && span_error) |-> (humidity == '0 && deficit == '0 && !watered && !pump_started), "span error result carries data")
  `MWC_ASSERT(a_start_needs_water, (out_valid && pump_started) |-> watered, "pump started without watering")
  `MWC_ASSERT(a_div_to_fin, (state == S_DIV && cnt == '0) |=> (state == S_FIN), "divider did not hand over")
  `MWC_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "reset left sequencer busy")

endmodule

`default_nettype wire
